// ----- rtl/afhtc_pkg.sv -----
// shared types and constants for the alarm flags unit
package afhtc_pkg;

  localparam int CODE_COUNT  = 16;
  localparam int CODE_W      = 4;
  localparam int FIRST_TIMED = 10;
  localparam int TIME_W      = 32;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 3;

  localparam int TIMED_COUNT_DEF   = 6;
  localparam int LOW_TEMP_BIT_DEF  = 0;
  localparam int HIGH_TEMP_BIT_DEF = 1;

  localparam int SETPOINT_W   = 14;
  localparam int THRESHOLD_W  = 11;
  localparam int HYSTERESIS_W = 10;
  localparam int LIMIT_W      = 15;
  localparam int HOLD_W       = 20;
  localparam int TEMP_W       = 15;
  localparam int CALC_W       = 17;

  localparam logic [SETPOINT_W-1:0]   SETPOINT_RST   = 14'd3650;
  localparam logic [THRESHOLD_W-1:0]  THRESHOLD_RST  = 11'd100;
  localparam logic [HYSTERESIS_W-1:0] HYSTERESIS_RST = 10'd20;
  localparam logic [LIMIT_W-1:0]      LIMIT_RST      = 15'd3900;
  localparam logic [HOLD_W-1:0]       HOLD_RST       = 20'd10000;

  typedef enum logic [1:0] {
    MODE_SET,
    MODE_CLEAR,
    MODE_TICK,
    MODE_SAMPLE
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SETPOINT,
    CFG_THRESHOLD,
    CFG_HYSTERESIS,
    CFG_LIMIT,
    CFG_HOLD
  } cfg_index_t;

  typedef struct packed {
    logic              set;
    logic              clr;
    logic [CODE_W-1:0] code;
  } flag_op_t;

endpackage

// ----- rtl/afhtc_temp_check.sv -----
// hysteresis check chain for one temperature sample
module afhtc_temp_check #(
  parameter int LOW_TEMP_BIT  = afhtc_pkg::LOW_TEMP_BIT_DEF,
  parameter int HIGH_TEMP_BIT = afhtc_pkg::HIGH_TEMP_BIT_DEF
) (
  input  logic signed [afhtc_pkg::TEMP_W-1:0]       temperature,
  input  logic        [afhtc_pkg::SETPOINT_W-1:0]   target_temp,
  input  logic        [afhtc_pkg::THRESHOLD_W-1:0]  temp_threshold,
  input  logic        [afhtc_pkg::HYSTERESIS_W-1:0] temp_hysteresis,
  input  logic        [afhtc_pkg::LIMIT_W-1:0]      temp_limit,
  input  logic        [afhtc_pkg::CODE_COUNT-1:0]   flags,
  output afhtc_pkg::flag_op_t                       op
);
  import afhtc_pkg::*;

  logic signed [CALC_W-1:0] t;
  logic signed [CALC_W-1:0] sp;
  logic signed [CALC_W-1:0] th;
  logic signed [CALC_W-1:0] hy;
  logic signed [CALC_W-1:0] lim;
  logic signed [CALC_W-1:0] low_set_lvl;
  logic signed [CALC_W-1:0] low_clr_lvl;
  logic signed [CALC_W-1:0] high_set_lvl;
  logic signed [CALC_W-1:0] high_clr_lvl;
  logic                     low_on;
  logic                     high_on;

  assign t   = {{(CALC_W-TEMP_W){temperature[TEMP_W-1]}}, temperature};
  assign sp  = {{(CALC_W-SETPOINT_W){target_temp[SETPOINT_W-1]}}, target_temp};
  assign th  = {{(CALC_W-THRESHOLD_W){1'b0}}, temp_threshold};
  assign hy  = {{(CALC_W-HYSTERESIS_W){1'b0}}, temp_hysteresis};
  assign lim = {{(CALC_W-LIMIT_W){temp_limit[LIMIT_W-1]}}, temp_limit};

  assign low_set_lvl  = sp - th - hy;
  assign low_clr_lvl  = sp - th + hy;
  assign high_set_lvl = sp + th + hy;
  assign high_clr_lvl = sp + th - hy;

  assign low_on  = flags[LOW_TEMP_BIT];
  assign high_on = flags[HIGH_TEMP_BIT];

  always_comb begin
    op = '0;
    if (!low_on && t < low_set_lvl) begin
      op.set  = 1'b1;
      op.code = CODE_W'(LOW_TEMP_BIT);
    end else if (low_on && t >= low_clr_lvl) begin
      op.clr  = 1'b1;
      op.code = CODE_W'(LOW_TEMP_BIT);
    end else if (!high_on && (t > high_set_lvl || t > lim)) begin
      op.set  = 1'b1;
      op.code = CODE_W'(HIGH_TEMP_BIT);
    end else if (high_on && t <= high_clr_lvl && t <= lim) begin
      op.clr  = 1'b1;
      op.code = CODE_W'(HIGH_TEMP_BIT);
    end
  end

endmodule

// ----- rtl/alarm_flags_hysteresis_timed_clear_unit.sv -----
// alarm flags unit: error word, timed self-clearing codes, temperature hysteresis
// a transaction passes through the input register and then the result register
// throughput: one transaction per cycle; the input register and result register
//   each move on every cycle that the result side is not stalled
// reset: synchronous; clears the flag word (not the error_word output), set times,
//   millisecond count and both pipeline valids, and loads the register reset values
module alarm_flags_hysteresis_timed_clear_unit #(
  parameter int TIMED_COUNT   = afhtc_pkg::TIMED_COUNT_DEF,
  parameter int LOW_TEMP_BIT  = afhtc_pkg::LOW_TEMP_BIT_DEF,
  parameter int HIGH_TEMP_BIT = afhtc_pkg::HIGH_TEMP_BIT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [afhtc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [afhtc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             mode,
  input  logic [afhtc_pkg::CODE_W-1:0]           code,
  input  logic signed [afhtc_pkg::TEMP_W-1:0]    temperature,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [afhtc_pkg::CODE_COUNT-1:0]       error_word,
  output logic                                   alarm_on
);
  import afhtc_pkg::*;

  localparam int TIMED_MAX  = CODE_COUNT - FIRST_TIMED;
  localparam int TIMED_USED = (TIMED_COUNT < TIMED_MAX) ? TIMED_COUNT : TIMED_MAX;

  logic [SETPOINT_W-1:0]   target_temp;
  logic [THRESHOLD_W-1:0]  temp_threshold;
  logic [HYSTERESIS_W-1:0] temp_hysteresis;
  logic [LIMIT_W-1:0]      temp_limit;
  logic [HOLD_W-1:0]       hold_ms;

  logic                     s1_valid;
  mode_t                    s1_mode;
  logic [CODE_W-1:0]        s1_code;
  logic signed [TEMP_W-1:0] s1_temperature;
  logic                     s1_advance;
  logic                     s1_fire;

  logic [CODE_COUNT-1:0] flags;
  logic [CODE_COUNT-1:0] flags_next;
  logic [TIME_W-1:0]     set_times      [TIMED_USED];
  logic [TIME_W-1:0]     set_times_next [TIMED_USED];
  logic [TIME_W-1:0]     now_ms;
  logic [TIME_W-1:0]     now_ms_next;
  logic [TIME_W-1:0]     age            [TIMED_USED];

  flag_op_t temp_op;
  flag_op_t op;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      target_temp     <= SETPOINT_RST;
      temp_threshold  <= THRESHOLD_RST;
      temp_hysteresis <= HYSTERESIS_RST;
      temp_limit      <= LIMIT_RST;
      hold_ms         <= HOLD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SETPOINT:   target_temp     <= cfg_data[SETPOINT_W-1:0];
        CFG_THRESHOLD:  temp_threshold  <= cfg_data[THRESHOLD_W-1:0];
        CFG_HYSTERESIS: temp_hysteresis <= cfg_data[HYSTERESIS_W-1:0];
        CFG_LIMIT:      temp_limit      <= cfg_data[LIMIT_W-1:0];
        CFG_HOLD:       hold_ms         <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  assign s1_advance = !out_valid || !out_stall;
  assign s1_fire    = s1_valid && s1_advance;
  assign in_stall   = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_mode        <= mode_t'(mode);
      s1_code        <= code;
      s1_temperature <= temperature;
    end
  end

  afhtc_temp_check #(
    .LOW_TEMP_BIT  (LOW_TEMP_BIT),
    .HIGH_TEMP_BIT (HIGH_TEMP_BIT)
  ) u_temp_check (
    .temperature     (s1_temperature),
    .target_temp     (target_temp),
    .temp_threshold  (temp_threshold),
    .temp_hysteresis (temp_hysteresis),
    .temp_limit      (temp_limit),
    .flags           (flags),
    .op              (temp_op)
  );

  always_comb begin
    op = '0;
    unique case (s1_mode)
      MODE_SET: begin
        op.set  = 1'b1;
        op.code = s1_code;
      end
      MODE_CLEAR: begin
        op.clr  = 1'b1;
        op.code = s1_code;
      end
      MODE_TICK:   op = '0;
      MODE_SAMPLE: op = temp_op;
      default:     op = '0;
    endcase
  end

  assign now_ms_next = (s1_fire && s1_mode == MODE_TICK) ? now_ms + TIME_W'(1) : now_ms;

  always_comb begin
    for (int i = 0; i < TIMED_USED; i++) begin
      age[i] = now_ms_next - set_times[i];
    end
  end

  always_comb begin
    flags_next     = flags;
    set_times_next = set_times;
    if (s1_fire) begin
      if (s1_mode == MODE_TICK) begin
        for (int i = 0; i < TIMED_USED; i++) begin
          if (flags[FIRST_TIMED+i] && age[i] >= {{(TIME_W-HOLD_W){1'b0}}, hold_ms}) begin
            flags_next[FIRST_TIMED+i] = 1'b0;
            set_times_next[i]         = '0;
          end
        end
      end else if (op.set) begin
        flags_next[op.code] = 1'b1;
        for (int i = 0; i < TIMED_USED; i++) begin
          if (op.code == CODE_W'(FIRST_TIMED + i)) begin
            set_times_next[i] = now_ms;
          end
        end
      end else if (op.clr) begin
        flags_next[op.code] = 1'b0;
      end
    end
  end

  // state
  always_ff @(posedge clk) begin
    if (rst) begin
      flags  <= '0;
      now_ms <= '0;
      for (int i = 0; i < TIMED_USED; i++) begin
        set_times[i] <= '0;
      end
    end else begin
      flags     <= flags_next;
      now_ms    <= now_ms_next;
      set_times <= set_times_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      error_word <= flags_next;
      alarm_on   <= |flags_next;
    end
  end

  a_set_reaches_output: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_mode == MODE_SET |=> out_valid && error_word[$past(s1_code)])
    else $error("set transaction did not raise its bit");

  a_clear_reaches_output: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_mode == MODE_CLEAR |=> out_valid && !error_word[$past(s1_code)])
    else $error("clear transaction left its bit set");

  a_tick_counts: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_mode == MODE_TICK |=> now_ms == $past(now_ms) + TIME_W'(1))
    else $error("tick did not advance the millisecond count");

  a_count_holds: assert property (@(posedge clk) disable iff (rst)
    !(s1_fire && s1_mode == MODE_TICK) |=> $stable(now_ms))
    else $error("millisecond count moved without a tick");

  a_alarm_matches: assert property (@(posedge clk) disable iff (rst)
    $past(s1_fire) |-> alarm_on == (error_word != '0))
    else $error("alarm does not match the error word");

endmodule
